>>> rtl/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg
// Types and constants shared by the bit-sliced index engine.
// ----------------------------------------------------------------------------
package bsi_pkg;

    localparam int ROWS       = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ROW_BITS   = $clog2(ROWS);
    localparam int WORDS      = (ROWS + 63) / 64;
    localparam int WORD_BITS  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int READ_WORDS = (WORDS < 16) ? WORDS : 16;
    localparam int CNT_BITS   = 11;

    typedef enum logic [3:0] {
        MODE_PUT     = 4'd0,
        MODE_GET     = 4'd1,
        MODE_REMOVE  = 4'd2,
        MODE_CLR_SEL = 4'd3,
        MODE_BELOW   = 4'd4,
        MODE_ABOVE   = 4'd5,
        MODE_EQUAL   = 4'd6,
        MODE_UNEQUAL = 4'd7,
        MODE_BETWEEN = 4'd8,
        MODE_MAX     = 4'd9,
        MODE_MIN     = 4'd10,
        MODE_RD_SEL  = 4'd11
    } mode_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [9:0]  row_id;
        logic [31:0] value;
        logic [31:0] value_high;
        logic        or_equal;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [10:0] match_count;
        logic [63:0] map_word;
        logic [3:0]  word_index;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_NORM_CHK,
        ST_NORM_WR,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SEL_WR,
        ST_EMIT,
        ST_RD_SEL
    } state_t;

endpackage

>>> rtl/bit_sliced_index_engine.sv
// ----------------------------------------------------------------------------
// bit_sliced_index_engine
// Column store with presence and selection maps and range queries.
// ----------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low; the word is taken at
// that edge and, for commands other than remove and clear selection, busy
// rises the next cycle. Results appear on rsp with valid high for one cycle
// each; last marks the final word of a command. The receiver cannot stall, so
// results are never held back.
// Values live in one single-port RAM of ROWS entries; presence and selection
// maps are flip-flops, cleared at reset. Put and get answer after the row
// read and row write states; remove and clear selection answer the next
// cycle. Range, max and min commands first check the selection, then stream
// every row through the value RAM one row per cycle; the RAM port sets the rate.
// Read selection emits one word per cycle for up to 16 words.
// Unequal rebuilds the selection from presence during the same row scan.
// After reset the block accepts a command at once.
// ----------------------------------------------------------------------------
module bit_sliced_index_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bsi_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           valid,
    output bsi_pkg::rsp_t  rsp
);

    localparam int RB = bsi_pkg::ROW_BITS;
    localparam int WB = bsi_pkg::WORD_BITS;
    localparam int VB = bsi_pkg::VALUE_BITS;

    bsi_pkg::state_t state_reg, state_next;
    bsi_pkg::cmd_t   cmd_reg;
    logic [bsi_pkg::ROWS-1:0] pres_reg, pres_next;
    logic [bsi_pkg::ROWS-1:0] sel_reg, sel_next;
    logic [RB:0]     cnt_reg, cnt_next;
    logic [RB-1:0]   prow_reg, prow_next;
    logic            pv_reg, pv_next;
    logic            empty_reg, empty_next;
    logic            any_reg, any_next;
    logic [VB-1:0]   best_reg, best_next;
    logic [bsi_pkg::CNT_BITS-1:0] n_reg, n_next;
    logic            valid_next;
    bsi_pkg::rsp_t   rsp_next;

    logic            ram_we;
    logic [RB-1:0]   ram_addr;
    logic [VB-1:0]   ram_wdata, ram_rdata;

    bsi_ram #(.WIDTH(VB), .DEPTH(bsi_pkg::ROWS)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    logic          row_ok;
    logic [RB-1:0] row;
    logic [VB-1:0] va, vb;
    logic          is_ext, is_max;
    logic          meets;

    always_comb
    begin
        row_ok = {22'd0, cmd_reg.row_id} < 32'(bsi_pkg::ROWS);
        row    = RB'(cmd_reg.row_id);
        va     = VB'(cmd_reg.value);
        vb     = VB'(cmd_reg.value_high);
        is_ext = (cmd_reg.mode == bsi_pkg::MODE_MAX) || (cmd_reg.mode == bsi_pkg::MODE_MIN);
        is_max = cmd_reg.mode == bsi_pkg::MODE_MAX;
        unique case (cmd_reg.mode)
            bsi_pkg::MODE_BELOW:   meets = cmd_reg.or_equal ? (ram_rdata <= va) : (ram_rdata < va);
            bsi_pkg::MODE_ABOVE:   meets = cmd_reg.or_equal ? (ram_rdata >= va) : (ram_rdata > va);
            bsi_pkg::MODE_EQUAL:   meets = ram_rdata == va;
            bsi_pkg::MODE_UNEQUAL: meets = ram_rdata != va;
            bsi_pkg::MODE_BETWEEN: meets = (ram_rdata >= va) && (ram_rdata <= vb);
            default:               meets = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.mode)
                        bsi_pkg::MODE_PUT, bsi_pkg::MODE_GET: state_next = bsi_pkg::ST_ROW_RD;
                        bsi_pkg::MODE_REMOVE, bsi_pkg::MODE_CLR_SEL:
                            state_next = bsi_pkg::ST_IDLE;
                        bsi_pkg::MODE_BELOW, bsi_pkg::MODE_ABOVE, bsi_pkg::MODE_EQUAL,
                        bsi_pkg::MODE_BETWEEN, bsi_pkg::MODE_MAX, bsi_pkg::MODE_MIN:
                            state_next = bsi_pkg::ST_NORM_CHK;
                        bsi_pkg::MODE_UNEQUAL: state_next = bsi_pkg::ST_SCAN_RD;
                        bsi_pkg::MODE_RD_SEL:  state_next = bsi_pkg::ST_RD_SEL;
                        default:               state_next = bsi_pkg::ST_EMIT;
                    endcase
                end
            end
            bsi_pkg::ST_ROW_RD:   state_next = bsi_pkg::ST_ROW_WR;
            bsi_pkg::ST_ROW_WR:   state_next = bsi_pkg::ST_IDLE;
            bsi_pkg::ST_NORM_CHK:
                if (cnt_reg == (RB+1)'(bsi_pkg::WORDS - 1)) state_next = bsi_pkg::ST_NORM_WR;
            bsi_pkg::ST_NORM_WR:  state_next = bsi_pkg::ST_SCAN_RD;
            bsi_pkg::ST_SCAN_RD:
                if (cnt_reg == (RB+1)'(bsi_pkg::ROWS - 1)) state_next = bsi_pkg::ST_SCAN_EVAL;
            bsi_pkg::ST_SCAN_EVAL: state_next = bsi_pkg::ST_SEL_WR;
            bsi_pkg::ST_SEL_WR:   state_next = bsi_pkg::ST_IDLE;
            bsi_pkg::ST_EMIT:     state_next = bsi_pkg::ST_IDLE;
            bsi_pkg::ST_RD_SEL:
                if (cnt_reg == (RB+1)'(bsi_pkg::READ_WORDS - 1)) state_next = bsi_pkg::ST_IDLE;
            default:              state_next = bsi_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pres_next  = pres_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        prow_next  = prow_reg;
        pv_next    = 1'b0;
        empty_next = empty_reg;
        any_next   = any_reg;
        best_next  = best_reg;
        n_next     = n_reg;
        valid_next = 1'b0;
        rsp_next   = '0;
        ram_we     = 1'b0;
        ram_addr   = row;
        ram_wdata  = va;
        unique case (state_reg)
            bsi_pkg::ST_IDLE:
            begin
                cnt_next   = '0;
                empty_next = 1'b1;
                any_next   = 1'b0;
                best_next  = '0;
                n_next     = '0;
                ram_addr   = RB'(cmd.row_id);
                if (start && (cmd.mode == bsi_pkg::MODE_REMOVE))
                begin
                    if ({22'd0, cmd.row_id} < 32'(bsi_pkg::ROWS))
                    begin
                        pres_next[RB'(cmd.row_id)] = 1'b0;
                    end
                    valid_next    = 1'b1;
                    rsp_next.last = 1'b1;
                end
                if (start && (cmd.mode == bsi_pkg::MODE_CLR_SEL))
                begin
                    sel_next      = '0;
                    valid_next    = 1'b1;
                    rsp_next.last = 1'b1;
                end
            end
            bsi_pkg::ST_ROW_RD:
            begin
                ram_addr = row;
            end
            bsi_pkg::ST_ROW_WR:
            begin
                valid_next    = 1'b1;
                rsp_next.last = 1'b1;
                if (row_ok && pres_reg[row])
                begin
                    rsp_next.found     = 1'b1;
                    rsp_next.value_out = 32'(ram_rdata);
                end
                if (row_ok && (cmd_reg.mode == bsi_pkg::MODE_PUT))
                begin
                    ram_we         = 1'b1;
                    pres_next[row] = 1'b1;
                end
            end
            bsi_pkg::ST_NORM_CHK:
            begin
                if (sel_reg[cnt_reg[WB-1:0]*64 +: 64] != 64'd0)
                begin
                    empty_next = 1'b0;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            bsi_pkg::ST_NORM_WR:
            begin
                sel_next = empty_reg ? pres_reg : (sel_reg & pres_reg);
                cnt_next = '0;
            end
            bsi_pkg::ST_SCAN_RD, bsi_pkg::ST_SCAN_EVAL, bsi_pkg::ST_SEL_WR:
            begin
                ram_addr = cnt_reg[RB-1:0];
                if (state_reg == bsi_pkg::ST_SCAN_RD)
                begin
                    pv_next   = 1'b1;
                    prow_next = cnt_reg[RB-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (cmd_reg.mode == bsi_pkg::MODE_UNEQUAL)
                    begin
                        sel_next[prow_reg] = pres_reg[prow_reg] && meets;
                    end
                    else if (is_ext)
                    begin
                        if (sel_reg[prow_reg])
                        begin
                            if (!any_reg || (is_max ? (ram_rdata > best_reg)
                                                    : (ram_rdata < best_reg)))
                            begin
                                any_next  = 1'b1;
                                best_next = ram_rdata;
                                n_next    = 11'd1;
                            end
                            else if ((ram_rdata == best_reg) && (n_reg != 11'h7ff))
                            begin
                                n_next = n_reg + 1'b1;
                            end
                        end
                    end
                    else if (!meets)
                    begin
                        sel_next[prow_reg] = 1'b0;
                    end
                end
                if (state_reg == bsi_pkg::ST_SEL_WR)
                begin
                    valid_next    = 1'b1;
                    rsp_next.last = 1'b1;
                    if (is_ext)
                    begin
                        rsp_next.value_out   = 32'(best_reg);
                        rsp_next.match_count = n_reg;
                    end
                end
            end
            bsi_pkg::ST_EMIT:
            begin
                valid_next    = 1'b1;
                rsp_next.last = 1'b1;
            end
            bsi_pkg::ST_RD_SEL:
            begin
                valid_next          = 1'b1;
                rsp_next.map_word   = sel_reg[cnt_reg[WB-1:0]*64 +: 64];
                rsp_next.word_index = 4'(cnt_reg);
                rsp_next.last       = cnt_reg == (RB+1)'(bsi_pkg::READ_WORDS - 1);
                cnt_next            = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsi_pkg::ST_IDLE;
            pres_reg  <= '0;
            sel_reg   <= '0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            valid     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pres_reg  <= pres_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            valid     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == bsi_pkg::ST_IDLE))
        begin
            cmd_reg <= cmd;
        end
        prow_reg  <= prow_next;
        empty_reg <= empty_next;
        any_reg   <= any_next;
        best_reg  <= best_next;
        n_reg     <= n_next;
        rsp       <= rsp_next;
    end

    assign busy = (state_reg != bsi_pkg::ST_IDLE);

endmodule

>>> rtl/bsi_ram.sv
// ----------------------------------------------------------------------------
// bsi_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
